>>> design/dcr_pkg.sv
// Shared types, constants and glyph font for the decimal digit column renderer.
package dcr_pkg;

    localparam int NUM_W   = 14;
    localparam int SX_W    = 7;
    localparam int X_W     = 8;
    localparam int Y_W     = 6;
    localparam int ROWS    = 9;
    localparam int GLYPH_W = 7;

    localparam logic [ROWS-1:0] BLANK_MASK = 9'h1FF;
    localparam logic [ROWS-1:0] DIGIT_MASK = 9'h17F;

    typedef logic [ROWS-1:0] column_t;

    // Font column c (0..2) of digit d, rows 0..6.
    function automatic logic [GLYPH_W-1:0] glyph_col(input logic [3:0] d, input logic [1:0] c);
        logic [23:0] row;
        logic [7:0]  b;
        unique case (d)
            4'd0:    row = 24'hFE82FE;
            4'd1:    row = 24'h00FE00;
            4'd2:    row = 24'hF2929E;
            4'd3:    row = 24'h9292FE;
            4'd4:    row = 24'h1E10FE;
            4'd5:    row = 24'h9E92F2;
            4'd6:    row = 24'hFE92F2;
            4'd7:    row = 24'h0202FE;
            4'd8:    row = 24'hFE92FE;
            4'd9:    row = 24'h9E92FE;
            default: row = 24'h000000;
        endcase
        unique case (c)
            2'd0:    b = row[23:16];
            2'd1:    b = row[15:8];
            2'd2:    b = row[7:0];
            default: b = 8'h00;
        endcase
        return b[GLYPH_W-1:0];
    endfunction

endpackage

>>> design/decimal_digit_column_renderer_core.sv
// Decimal digit column renderer: bit-serial BCD conversion and column sequencer.
// The input is converted in 14 shift-add-3 steps, one per bit, before the first column.
// Then one column per cycle, but none while a suppressed leading zero is dropped.
// Busy stays high until the last column is issued.
// Columns appear for one cycle on strobe; the receiver cannot stall.
// Reset (rst_n, async, active low) returns to idle with no strobe pending.
module decimal_digit_column_renderer_core
    import dcr_pkg::*;
#(
    parameter int MAX_DIGITS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_W-1:0]    number,
    input  logic [SX_W-1:0]     start_x,
    input  logic [Y_W-1:0]      start_y,
    output logic                busy,
    output logic                strobe,
    output logic [X_W-1:0]      column_x,
    output logic [Y_W-1:0]      top_y,
    output logic [ROWS-1:0]     pixel_bits,
    output logic [ROWS-1:0]     row_write_mask,
    output logic                is_last
);

    localparam int BW    = 4 * MAX_DIGITS;
    localparam int DC_W  = $clog2(MAX_DIGITS + 1);
    localparam int BC_W  = $clog2(NUM_W);
    localparam logic [NUM_W-1:0] NUM_MAX = NUM_W'(10 ** MAX_DIGITS - 1);
    localparam logic [BC_W-1:0]  LAST_BIT = BC_W'(NUM_W - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_LEAD  = 3'd2;
    localparam logic [2:0] S_DIGIT = 3'd3;
    localparam logic [2:0] S_GAP   = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [NUM_W-1:0] sh_reg, sh_next;
    logic [BW-1:0]    bcd_reg, bcd_next, adj;
    logic [BC_W-1:0]  bit_reg, bit_next;
    logic [DC_W-1:0]  dig_reg, dig_next;
    logic [1:0]       col_reg, col_next;
    logic             started_reg, started_next;
    logic             zero_reg, zero_next;
    logic [X_W-1:0]   x_reg, x_next;
    logic [Y_W-1:0]   y_reg, y_next;

    logic             stb_reg, stb_next;
    logic [X_W-1:0]   ox_reg, ox_next;
    column_t          opix_reg, opix_next;
    column_t          omask_reg, omask_next;
    logic             olast_reg, olast_next;

    logic [3:0]       cur_digit;

    assign cur_digit = bcd_reg[BW-1 -: 4];

    always_comb
    begin
        logic [3:0] nib;
        adj = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            nib = bcd_reg[4*i +: 4];
            adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        sh_next      = sh_reg;
        bcd_next     = bcd_reg;
        bit_next     = bit_reg;
        dig_next     = dig_reg;
        col_next     = col_reg;
        started_next = started_reg;
        zero_next    = zero_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        stb_next     = 1'b0;
        ox_next      = ox_reg;
        opix_next    = opix_reg;
        omask_next   = omask_reg;
        olast_next   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    sh_next    = (number > NUM_MAX) ? NUM_MAX : number;
                    zero_next  = (number == '0);
                    bcd_next   = '0;
                    bit_next   = '0;
                    x_next     = {1'b0, start_x};
                    y_next     = start_y;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                bcd_next = {adj[BW-2:0], sh_reg[NUM_W-1]};
                sh_next  = sh_reg << 1;
                bit_next = bit_reg + 1'b1;
                if (bit_reg == LAST_BIT)
                    state_next = S_LEAD;
            end
            S_LEAD:
            begin
                stb_next     = 1'b1;
                ox_next      = x_reg;
                opix_next    = '0;
                omask_next   = BLANK_MASK;
                olast_next   = zero_reg;
                x_next       = x_reg + 1'b1;
                dig_next     = DC_W'(MAX_DIGITS);
                col_next     = '0;
                started_next = 1'b0;
                state_next   = zero_reg ? S_IDLE : S_DIGIT;
            end
            S_DIGIT:
            begin
                if (!started_reg && cur_digit == 4'd0)
                begin
                    // leading zero: drop it, no column
                    bcd_next = bcd_reg << 4;
                    dig_next = dig_reg - 1'b1;
                end
                else
                begin
                    started_next = 1'b1;
                    stb_next     = 1'b1;
                    ox_next      = x_reg;
                    omask_next   = DIGIT_MASK;
                    opix_next    = {2'b00, glyph_col(cur_digit,
                                    (cur_digit == 4'd1) ? 2'd1 : col_reg)};
                    x_next       = x_reg + 1'b1;
                    if (cur_digit == 4'd1 || col_reg == 2'd2)
                    begin
                        col_next   = '0;
                        bcd_next   = bcd_reg << 4;
                        dig_next   = dig_reg - 1'b1;
                        state_next = S_GAP;
                    end
                    else
                        col_next = col_reg + 1'b1;
                end
            end
            S_GAP:
            begin
                stb_next   = 1'b1;
                ox_next    = x_reg;
                opix_next  = '0;
                omask_next = BLANK_MASK;
                olast_next = (dig_reg == '0);
                x_next     = x_reg + 1'b1;
                state_next = (dig_reg == '0) ? S_IDLE : S_DIGIT;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            stb_reg     <= 1'b0;
            olast_reg   <= 1'b0;
            started_reg <= 1'b0;
            bit_reg     <= '0;
            dig_reg     <= '0;
            col_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            stb_reg     <= stb_next;
            olast_reg   <= olast_next;
            started_reg <= started_next;
            bit_reg     <= bit_next;
            dig_reg     <= dig_next;
            col_reg     <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg    <= sh_next;
        bcd_reg   <= bcd_next;
        zero_reg  <= zero_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        ox_reg    <= ox_next;
        opix_reg  <= opix_next;
        omask_reg <= omask_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign strobe         = stb_reg;
    assign column_x       = ox_reg;
    assign top_y          = y_reg;
    assign pixel_bits     = opix_reg;
    assign row_write_mask = omask_reg;
    assign is_last        = olast_reg;

endmodule

>>> design/dcr_checker.sv
// Port-level checker for the decimal digit column renderer, bound to the top level.
module dcr_checker
    import dcr_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic            strobe,
    input logic [X_W-1:0]  column_x,
    input logic [ROWS-1:0] pixel_bits,
    input logic [ROWS-1:0] row_write_mask,
    input logic            is_last
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !is_last |-> busy)
        else $error("column of an unfinished run while idle");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !is_last |=> !strobe || column_x == $past(column_x) + 8'd1)
        else $error("column_x did not advance by one");

    a_col_kind: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (row_write_mask == BLANK_MASK && pixel_bits == '0) ||
                   (row_write_mask == DIGIT_MASK && pixel_bits[8:7] == 2'b00))
        else $error("bad column mask or pixels");

    a_last_blank: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && is_last |-> row_write_mask == BLANK_MASK && !busy)
        else $error("run does not end on a blank column");

endmodule

bind decimal_digit_column_renderer_core dcr_checker u_dcr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .strobe         (strobe),
    .column_x       (column_x),
    .pixel_bits     (pixel_bits),
    .row_write_mask (row_write_mask),
    .is_last        (is_last)
);
